@@ sv/fedf_pkg.sv @@
// ----------------------------------------------------------------------------
// fedf_pkg
// Shared types and constants for the FIFO / EDF waiter arbiter.
// ----------------------------------------------------------------------------
package fedf_pkg;

    // Default list depth
    localparam int MAX_WAITERS_DEF = 4;

    // Command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CHECK  = 2'd2;

    // Selection policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_EDF  = 1'b1;

    // One stored waiter
    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] arrival;
        logic [31:0] deadline;
    } entry_t;

    // Input word
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  requester_id;
        logic [31:0] arrival_time;
        logic [31:0] deadline_time;
    } in_item_t;

    // Result word
    typedef struct packed {
        logic        is_turn;
        logic [7:0]  chosen_id;
        logic        chosen_valid;
        logic [4:0]  waiter_count;
        logic        add_refused;
    } out_item_t;

endpackage

@@ sv/fedf_cmp.sv @@
// ----------------------------------------------------------------------------
// fedf_cmp
// Shared compare unit: tells whether a candidate waiter beats the best so far.
// ----------------------------------------------------------------------------
module fedf_cmp (
    input  logic             policy,
    input  fedf_pkg::entry_t cand,
    input  fedf_pkg::entry_t best,
    output logic             better
);
    import fedf_pkg::*;

    logic arr_less;
    logic dl_less;
    logic dl_equal;

    assign arr_less = cand.arrival < best.arrival;
    assign dl_less  = cand.deadline < best.deadline;
    assign dl_equal = cand.deadline == best.deadline;

    // Strict compares: ties keep the lower list position
    always_comb begin
        if (policy == POLICY_EDF) begin
            better = dl_less || (dl_equal && arr_less);
        end else begin
            better = arr_less;
        end
    end

endmodule

@@ sv/fedf_list.sv @@
// ----------------------------------------------------------------------------
// fedf_list
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fedf_list #(
    parameter int WIDTH = 8,
    parameter int DEPTH = fedf_pkg::MAX_WAITERS_DEF,
    parameter int IDX_W = $clog2((DEPTH > 1) ? DEPTH : 2)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write-first: a read of the address being written returns the new word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_idx] <= wr_data;
        end
        if (wr_en && (wr_idx == rd_idx)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem_reg[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/fifo_edf_waiter_arbiter.sv @@
// ----------------------------------------------------------------------------
// fifo_edf_waiter_arbiter
// Waiting list for one shared resource with FIFO or EDF selection.
// ----------------------------------------------------------------------------
// Each input word is one command (add, remove or check) against a list of up
// to MAX_WAITERS waiters; each command returns exactly one result word naming
// the waiter to serve next. The block works on one word at a time: s_ready is
// high only while the sequencer is idle. A word is taken in the idle state,
// then for remove the list is searched for the id and the gap behind it is
// closed, then a selection scan walks the list (at its size after the
// command) through the one registered list read port, addressed one position
// ahead, and the shared compare unit, and then the result register is loaded.
// The result register lets the next word in while a result is still waiting
// on m_ready. Policy is to be written through policy_we / policy_wdata only
// while idle; the block itself does not enforce this. 0 picks the oldest
// arrival, 1 the earliest deadline with ties to the oldest arrival; any
// remaining tie goes to the lowest list position.
// ----------------------------------------------------------------------------
module fifo_edf_waiter_arbiter #(
    parameter int MAX_WAITERS = fedf_pkg::MAX_WAITERS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                policy_we,
    input  logic                policy_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  fedf_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output fedf_pkg::out_item_t m_item
);
    import fedf_pkg::*;

    localparam int IDX_W = $clog2((MAX_WAITERS > 1) ? MAX_WAITERS : 2);
    localparam int CNT_W = $clog2(MAX_WAITERS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WAITERS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SHIFT,
        S_PICK,
        S_DONE
    } state_t;

    state_t           state_reg,     state_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic [CNT_W-1:0] scan_reg,      scan_next;
    logic [7:0]       id_reg,        id_next;
    logic             refused_reg,   refused_next;
    entry_t           best_reg,      best_next;
    out_item_t        out_reg,       out_next;
    logic             out_valid_reg, out_valid_next;
    logic             policy_reg;

    logic [CNT_W-1:0] scan_inc;
    logic [CNT_W-1:0] scan_inc2;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_idx;
    entry_t           rd_data;
    logic             better;
    logic             list_full;
    logic             list_any;

    fedf_list #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_WAITERS),
        .IDX_W (IDX_W)
    ) u_list (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    fedf_cmp u_cmp (
        .policy (policy_reg),
        .cand   (rd_data),
        .best   (best_reg),
        .better (better)
    );

    assign scan_inc  = scan_reg + 1'b1;
    assign scan_inc2 = scan_inc + 1'b1;
    assign list_full = count_reg == CNT_MAX;
    assign list_any  = count_reg != '0;

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    // The list read port is registered: rd_idx names the entry that rd_data
    // holds in the next cycle, so each state addresses one position ahead.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        id_next        = id_reg;
        refused_next   = refused_reg;
        best_next      = best_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        wr_idx         = count_reg[IDX_W-1:0];
        wr_data        = '{id:       s_item.requester_id,
                           arrival:  s_item.arrival_time,
                           deadline: s_item.deadline_time};
        rd_idx         = '0;

        // Drop the result once the sink takes it
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    id_next      = s_item.requester_id;
                    scan_next    = '0;
                    refused_next = 1'b0;
                    state_next   = S_PICK;
                    case (s_item.command)
                        CMD_ADD: begin
                            // Append at the tail, or flag a full list
                            if (list_full) begin
                                refused_next = 1'b1;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            state_next = S_FIND;
                        end
                        default: begin
                            // Check and the unused code change nothing
                        end
                    endcase
                end
            end
            S_FIND: begin
                // Search for the first matching id, one position a cycle
                if (scan_reg == count_reg) begin
                    scan_next  = '0;
                    state_next = S_PICK;
                end else if (rd_data.id == id_reg) begin
                    // Fetch the entry behind the match for the shift
                    rd_idx     = scan_inc[IDX_W-1:0];
                    state_next = S_SHIFT;
                end else begin
                    rd_idx    = scan_inc[IDX_W-1:0];
                    scan_next = scan_inc;
                end
            end
            S_SHIFT: begin
                // Close the gap: move each later entry down one place
                if (scan_inc < count_reg) begin
                    rd_idx    = scan_inc2[IDX_W-1:0];
                    wr_en     = 1'b1;
                    wr_idx    = scan_reg[IDX_W-1:0];
                    wr_data   = rd_data;
                    scan_next = scan_inc;
                end else begin
                    count_next = count_reg - 1'b1;
                    scan_next  = '0;
                    state_next = S_PICK;
                end
            end
            S_PICK: begin
                // Walk the list, keep the best waiter seen so far
                if (scan_reg == count_reg) begin
                    state_next = S_DONE;
                end else begin
                    if (scan_reg == '0 || better) begin
                        best_next = rd_data;
                    end
                    rd_idx    = scan_inc[IDX_W-1:0];
                    scan_next = scan_inc;
                end
            end
            S_DONE: begin
                // Load the result once the output register is free
                if (!out_valid_reg || m_ready) begin
                    out_next.is_turn      = list_any && (best_reg.id == id_reg);
                    out_next.chosen_id    = list_any ? best_reg.id : 8'd0;
                    out_next.chosen_valid = list_any;
                    out_next.waiter_count = 5'(count_reg);
                    out_next.add_refused  = refused_reg;
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
        id_reg      <= id_next;
        refused_reg <= refused_next;
        best_reg    <= best_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POLICY_FIFO;
        end else if (policy_we) begin
            policy_reg <= policy_wdata;
        end
    end

    // The list never grows past its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("waiter count exceeds list depth");

    // A refused add leaves the list untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_item.command == CMD_ADD && list_full)
        |=> count_reg == $past(count_reg))
        else $error("refused add changed the waiter count");

    // The selection scan never changes the list size
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PICK) |=> count_reg == $past(count_reg))
        else $error("waiter count changed during selection");

    // A result names a waiter exactly when the list is not empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.chosen_valid == (m_item.waiter_count != 5'd0)))
        else $error("chosen_valid disagrees with waiter_count");

    // A turn is only granted to a chosen waiter
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.is_turn) |-> m_item.chosen_valid)
        else $error("is_turn raised on an empty list");

endmodule

@@ tb/fifo_edf_waiter_arbiter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_edf_waiter_arbiter_tb
// Self-checking bench for the FIFO / EDF waiter arbiter.
// ----------------------------------------------------------------------------
// Each command word sent to the block also runs through a local model of the
// waiting list, and the predicted result word is queued. Every result word
// that leaves the block is compared field by field with the oldest queued
// prediction. A few directed tests cover the empty list, a full list, absent
// and duplicate ids, the spare command code and ties under both policies.
// Random phases follow under both policies, with random idle cycles on both
// handshakes, a stretch with no idling and a phase that stops sending until
// the list of predictions has emptied.
// ----------------------------------------------------------------------------
module fifo_edf_waiter_arbiter_tb;
    import fedf_pkg::*;

    localparam int DEPTH = MAX_WAITERS_DEF;
    // The block treats the spare code as a check
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int IDLE_MAX = 5;
    // Covers a word's worst case: accept, search, shift, scan, result load
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX = 10;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      policy_we;
    logic      policy_wdata;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // Local copy of the waiting list and the policy register
    entry_t    roster [DEPTH];
    int        roster_len;
    logic      cur_policy;

    // Predicted result words, oldest first
    out_item_t pending_turns [$];
    out_item_t turn_want;
    int        mismatches;
    int        cycle_cnt = 0;

    // Switch off idle cycles on the word or result side
    bit        tx_calm;
    bit        rx_calm;

    fifo_edf_waiter_arbiter #(
        .MAX_WAITERS (DEPTH)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .policy_we    (policy_we),
        .policy_wdata (policy_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // List model: apply one command, then pick the waiter to serve
    // ------------------------------------------------------------------------
    function automatic out_item_t apply_command(in_item_t w);
        out_item_t r;
        int        k;
        int        best;
        bit        hit;
        r = '0;
        hit = 1'b0;
        if (w.command == CMD_ADD) begin
            if (roster_len >= DEPTH) begin
                r.add_refused = 1'b1;
            end else begin
                roster[roster_len].id       = w.requester_id;
                roster[roster_len].arrival  = w.arrival_time;
                roster[roster_len].deadline = w.deadline_time;
                roster_len++;
            end
        end else if (w.command == CMD_REMOVE) begin
            // Drop the first match only; close the gap behind it
            for (k = 0; k < roster_len; k++) begin
                if (hit) begin
                    roster[k - 1] = roster[k];
                end else if (roster[k].id == w.requester_id) begin
                    hit = 1'b1;
                end
            end
            if (hit) begin
                roster_len--;
            end
        end
        if (roster_len != 0) begin
            best = 0;
            // Strict compares keep the lowest position on a full tie
            for (k = 1; k < roster_len; k++) begin
                if (cur_policy == POLICY_FIFO) begin
                    if (roster[k].arrival < roster[best].arrival) begin
                        best = k;
                    end
                end else if (roster[k].deadline < roster[best].deadline ||
                             (roster[k].deadline == roster[best].deadline &&
                              roster[k].arrival < roster[best].arrival)) begin
                    best = k;
                end
            end
            r.chosen_valid = 1'b1;
            r.chosen_id    = roster[best].id;
            r.is_turn      = (roster[best].id == w.requester_id);
        end
        r.waiter_count = 5'(roster_len);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------
    function automatic in_item_t word(logic [1:0] cmd, logic [7:0] id,
                                      logic [31:0] arr, logic [31:0] dl);
        in_item_t w;
        w.command       = cmd;
        w.requester_id  = id;
        w.arrival_time  = arr;
        w.deadline_time = dl;
        return w;
    endfunction

    // Mix of extremes, small values (ties are common) and full range
    function automatic logic [31:0] pick_time();
        logic [31:0] t;
        case ($urandom_range(0, 5))
            0:       t = 32'h0000_0000;
            1:       t = 32'hFFFF_FFFF;
            2, 3:    t = 32'($urandom_range(0, 7));
            default: t = $urandom;
        endcase
        return t;
    endfunction

    // A narrow id pool half the time so duplicates show up
    function automatic logic [7:0] pick_id();
        logic [7:0] id;
        if ($urandom_range(0, 1) == 0) begin
            id = 8'($urandom_range(0, 7));
        end else begin
            id = 8'($urandom_range(0, 255));
        end
        return id;
    endfunction

    // Tidy words act on waiters that exist; the rest is plain noise
    function automatic in_item_t make_request(bit tidy);
        in_item_t w;
        int       roll;
        w = word(CMD_CHECK, pick_id(), pick_time(), pick_time());
        roll = $urandom_range(0, 9);
        if (!tidy) begin
            w.command = 2'($urandom_range(0, 3));
        end else if (roster_len == 0 || (roll < 4 && roster_len < DEPTH) || roll == 9) begin
            // roll 9 adds even on a full list
            w.command = CMD_ADD;
        end else if (roll < 7) begin
            w.command      = CMD_REMOVE;
            w.requester_id = roster[$urandom_range(0, roster_len - 1)].id;
        end else if (roll == 7) begin
            w.requester_id = roster[$urandom_range(0, roster_len - 1)].id;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Driving side: called and returning at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_word(in_item_t w);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_item  <= w;
        s_valid <= 1'b1;
        pending_turns.push_back(apply_command(w));
        // Hold the word until the block takes it
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid, wait for every predicted word, then let the block go idle
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_turns.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Only while idle
    task automatic write_policy(logic pol);
        policy_we    <= 1'b1;
        policy_wdata <= pol;
        @(negedge aclk);
        policy_we    <= 1'b0;
        cur_policy   = pol;
    endtask

    task automatic run_random(int n, logic pol, int tidy_pct, int pause_every);
        int i;
        settle();
        write_policy(pol);
        for (i = 0; i < n; i++) begin
            // Stop sending until the list of predictions is empty
            if (pause_every > 0 && i > 0 && i % pause_every == 0) begin
                settle();
            end
            send_word(make_request($urandom_range(0, 99) < tidy_pct));
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Empty list: id 0 still must not get the turn
    task automatic test_empty_list();
        send_word(word(CMD_CHECK, 8'd0, 32'h0, 32'h0));
        send_word(word(CMD_REMOVE, 8'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(word(CMD_SPARE, 8'd255, $urandom, $urandom));
    endtask

    // Oldest arrival first: ties, full list, absent and duplicate ids
    task automatic test_fifo_order();
        send_word(word(CMD_ADD, 8'd0, 32'hFFFF_FFFF, 32'h0));
        send_word(word(CMD_ADD, 8'd255, 32'h0, 32'hFFFF_FFFF));
        // Same arrival as position 1: the lower position keeps the turn
        send_word(word(CMD_ADD, 8'd7, 32'h0, 32'd5));
        send_word(word(CMD_ADD, 8'd7, 32'd10, 32'h0));
        // Full list: refused, nothing stored
        send_word(word(CMD_ADD, 8'd9, 32'd1, 32'd1));
        send_word(word(CMD_REMOVE, 8'd3, 32'h0, 32'h0));
        send_word(word(CMD_CHECK, 8'd255, 32'h0, 32'h0));
        // Duplicate id: only the first copy leaves, the tail shifts down
        send_word(word(CMD_REMOVE, 8'd7, 32'h0, 32'h0));
        send_word(word(CMD_REMOVE, 8'd255, 32'h0, 32'h0));
        send_word(word(CMD_SPARE, 8'd7, $urandom, $urandom));
    endtask

    // Earliest deadline first, ties to the older arrival, then to position
    task automatic test_edf_order();
        settle();
        write_policy(POLICY_EDF);
        send_word(word(CMD_CHECK, 8'd0, 32'h0, 32'h0));
        send_word(word(CMD_ADD, 8'd1, 32'd10, 32'h0));
        send_word(word(CMD_ADD, 8'd2, 32'd3, 32'h0));
        send_word(word(CMD_ADD, 8'd200, 32'h0, 32'hFFFF_FFFF));
        send_word(word(CMD_REMOVE, 8'd2, 32'h0, 32'h0));
        send_word(word(CMD_REMOVE, 8'd7, 32'h0, 32'h0));
        send_word(word(CMD_REMOVE, 8'd1, 32'h0, 32'h0));
        send_word(word(CMD_REMOVE, 8'd0, 32'h0, 32'h0));
    endtask

    task automatic test_fifo_random();
        run_random(360, POLICY_FIFO, 85, 0);
    endtask

    // Sender pauses every so often until all results are back
    task automatic test_edf_paused();
        run_random(360, POLICY_EDF, 85, 90);
    endtask

    task automatic test_fifo_back_to_back();
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        run_random(350, POLICY_FIFO, 85, 0);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // Mostly noise, receiver never stalls
    task automatic test_edf_noise();
        rx_calm = 1'b1;
        run_random(360, POLICY_EDF, 40, 0);
        rx_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall before each word, then hold ready
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, IDLE_MAX);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_turns.size() == 0) begin
                if (mismatches < REPORT_MAX) begin
                    $display("unexpected result word: turn=%0b id=%0d valid=%0b count=%0d refused=%0b",
                             m_item.is_turn, m_item.chosen_id, m_item.chosen_valid,
                             m_item.waiter_count, m_item.add_refused);
                end
                mismatches++;
            end else begin
                turn_want = pending_turns.pop_front();
                if (m_item.is_turn !== turn_want.is_turn ||
                    m_item.chosen_id !== turn_want.chosen_id ||
                    m_item.chosen_valid !== turn_want.chosen_valid ||
                    m_item.waiter_count !== turn_want.waiter_count ||
                    m_item.add_refused !== turn_want.add_refused) begin
                    if (mismatches < REPORT_MAX) begin
                        $display("result mismatch: expected turn=%0b id=%0d valid=%0b count=%0d refused=%0b",
                                 turn_want.is_turn, turn_want.chosen_id, turn_want.chosen_valid,
                                 turn_want.waiter_count, turn_want.add_refused);
                        $display("                 actual   turn=%0b id=%0d valid=%0b count=%0d refused=%0b",
                                 m_item.is_turn, m_item.chosen_id, m_item.chosen_valid,
                                 m_item.waiter_count, m_item.add_refused);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("fifo_edf_waiter_arbiter_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn      = 1'b0;
        policy_we    = 1'b0;
        policy_wdata = 1'b0;
        s_valid      = 1'b0;
        s_item       = '0;
        roster_len   = 0;
        cur_policy   = POLICY_FIFO;
        mismatches   = 0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_list();
        test_fifo_order();
        test_edf_order();
        test_fifo_random();
        test_edf_paused();
        test_fifo_back_to_back();
        test_edf_noise();
        settle();

        if (mismatches == 0) begin
            $display("fifo_edf_waiter_arbiter_tb: PASS");
        end else begin
            $display("fifo_edf_waiter_arbiter_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/fedf_pkg.sv
sv/fedf_cmp.sv
sv/fedf_list.sv
sv/fifo_edf_waiter_arbiter.sv
tb/fifo_edf_waiter_arbiter_tb.sv
